/* design/prq_pkg.sv */
package prq_pkg;

    // fixed widths of the channel fields
    localparam int OP_W       = 1;
    localparam int IN_TAG_W   = 8;
    localparam int IN_PRIO_W  = 8;
    localparam int STATUS_W   = 2;
    localparam int OUT_TAG_W  = 8;
    localparam int OUT_PRIO_W = 8;
    localparam int HELD_W     = 4;

    // defaults for the top level parameters
    localparam int DEF_QUEUE_DEPTH   = 8;
    localparam int DEF_TAG_BITS      = 8;
    localparam int DEF_PRIORITY_BITS = 8;

    localparam logic [OP_W-1:0] OP_INSERT = 1'b0;
    localparam logic [OP_W-1:0] OP_REMOVE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic load;     // request taken this cycle: update queue, load result
    } t_dp_cmd;

    // datapath -> top
    typedef struct packed {
        logic full;
        logic empty;
    } t_dp_stat;

endpackage

/* design/prq_ctrl.sv */
module prq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    output prq_pkg::t_dp_cmd  o_cmd
);
    import prq_pkg::*;

    typedef enum logic {
        S_IDLE,     // result register empty
        S_HOLD      // result waiting for the receiver
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   take;

    // a new request can enter whenever the result register is free or drains now
    assign o_ready    = (r_state == S_IDLE) || i_ready;
    assign take       = i_valid && o_ready;
    assign o_valid    = (r_state == S_HOLD);
    assign o_cmd.load = take;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (take) n_state = S_HOLD;
            end
            S_HOLD: begin
                if (i_ready && !take) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* design/prq_datapath.sv */
module prq_datapath #(
    parameter int QUEUE_DEPTH   = prq_pkg::DEF_QUEUE_DEPTH,
    parameter int TAG_BITS      = prq_pkg::DEF_TAG_BITS,
    parameter int PRIORITY_BITS = prq_pkg::DEF_PRIORITY_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  prq_pkg::t_dp_cmd                 i_cmd,
    output prq_pkg::t_dp_stat                o_stat,
    input  logic [prq_pkg::OP_W-1:0]         i_operation,
    input  logic [prq_pkg::IN_TAG_W-1:0]     i_task_tag,
    input  logic [prq_pkg::IN_PRIO_W-1:0]    i_task_priority,
    output logic [prq_pkg::STATUS_W-1:0]     o_status,
    output logic [prq_pkg::OUT_TAG_W-1:0]    o_out_tag,
    output logic [prq_pkg::OUT_PRIO_W-1:0]   o_out_priority,
    output logic [prq_pkg::HELD_W-1:0]       o_held_count
);
    import prq_pkg::*;

    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int TIN_W  = (TAG_BITS > IN_TAG_W) ? TAG_BITS : IN_TAG_W;
    localparam int PIN_W  = (PRIORITY_BITS > IN_PRIO_W) ? PRIORITY_BITS : IN_PRIO_W;
    localparam int TOUT_W = (TAG_BITS > OUT_TAG_W) ? TAG_BITS : OUT_TAG_W;
    localparam int POUT_W = (PRIORITY_BITS > OUT_PRIO_W) ? PRIORITY_BITS : OUT_PRIO_W;
    localparam int HOUT_W = (CNT_W > HELD_W) ? CNT_W : HELD_W;

    // cell row, slot 0 is the head
    logic [TAG_BITS-1:0]      r_tag   [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] r_prio  [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]   r_valid;
    logic [CNT_W-1:0]         r_count;

    logic [TAG_BITS-1:0]      n_tag   [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] n_prio  [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]   n_valid;
    logic [CNT_W-1:0]         n_count;

    logic [TAG_BITS-1:0]      up_tag  [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] up_prio [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]      dn_tag  [QUEUE_DEPTH];
    logic [PRIORITY_BITS-1:0] dn_prio [QUEUE_DEPTH];

    logic [QUEUE_DEPTH:0]     ge_ext;   // bit i+1: cell i stays ahead of the new entry
    logic [TIN_W-1:0]         tag_in_w;
    logic [PIN_W-1:0]         prio_in_w;
    logic [TAG_BITS-1:0]      new_tag;
    logic [PRIORITY_BITS-1:0] new_prio;
    logic [TOUT_W-1:0]        head_tag_w;
    logic [POUT_W-1:0]        head_prio_w;
    logic [HOUT_W-1:0]        count_w;

    logic     is_remove;
    logic     do_insert;
    logic     do_remove;
    t_status  res_status;

    logic [STATUS_W-1:0]   r_status;
    logic [OUT_TAG_W-1:0]  r_out_tag;
    logic [OUT_PRIO_W-1:0] r_out_prio;
    logic [HELD_W-1:0]     r_held;

    assign tag_in_w  = TIN_W'(i_task_tag);
    assign prio_in_w = PIN_W'(i_task_priority);
    assign new_tag   = tag_in_w[TAG_BITS-1:0];
    assign new_prio  = prio_in_w[PRIORITY_BITS-1:0];

    assign o_stat.full  = r_valid[QUEUE_DEPTH-1];
    assign o_stat.empty = !r_valid[0];

    assign is_remove = (i_operation == OP_REMOVE);
    assign do_insert = i_cmd.load && !is_remove && !o_stat.full;
    assign do_remove = i_cmd.load && is_remove && !o_stat.empty;

    // neighbor views of the row
    always_comb begin
        up_tag[0]  = '0;
        up_prio[0] = '0;
        for (int i = 1; i < QUEUE_DEPTH; i++) begin
            up_tag[i]  = r_tag[i-1];
            up_prio[i] = r_prio[i-1];
        end
        for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            dn_tag[i]  = r_tag[i+1];
            dn_prio[i] = r_prio[i+1];
        end
        dn_tag[QUEUE_DEPTH-1]  = '0;
        dn_prio[QUEUE_DEPTH-1] = '0;
    end

    // all cells compare against the new priority at once
    always_comb begin
        ge_ext[0] = 1'b1;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            ge_ext[i+1] = r_valid[i] && (r_prio[i] >= new_prio);
        end
    end

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            n_tag[i]  = r_tag[i];
            n_prio[i] = r_prio[i];
        end
        n_valid = r_valid;
        n_count = r_count;
        if (do_insert) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                if (ge_ext[i+1]) begin
                    n_tag[i]  = r_tag[i];
                    n_prio[i] = r_prio[i];
                end else if (ge_ext[i]) begin
                    n_tag[i]  = new_tag;
                    n_prio[i] = new_prio;
                end else begin
                    n_tag[i]  = up_tag[i];
                    n_prio[i] = up_prio[i];
                end
            end
            n_valid = {r_valid[QUEUE_DEPTH-2:0], 1'b1} | r_valid;
            n_count = r_count + CNT_W'(1);
        end else if (do_remove) begin
            for (int i = 0; i < QUEUE_DEPTH; i++) begin
                n_tag[i]  = dn_tag[i];
                n_prio[i] = dn_prio[i];
            end
            n_valid = {1'b0, r_valid[QUEUE_DEPTH-1:1]};
            n_count = r_count - CNT_W'(1);
        end
    end

    always_comb begin
        if (i_cmd.load && !is_remove && o_stat.full) begin
            res_status = ST_FULL;
        end else if (i_cmd.load && is_remove && o_stat.empty) begin
            res_status = ST_EMPTY;
        end else begin
            res_status = ST_DONE;
        end
    end

    assign head_tag_w  = TOUT_W'(r_tag[0]);
    assign head_prio_w = POUT_W'(r_prio[0]);
    assign count_w     = HOUT_W'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
        end else begin
            r_valid <= n_valid;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            r_tag[i]  <= n_tag[i];
            r_prio[i] <= n_prio[i];
        end
        if (i_cmd.load) begin
            r_status   <= res_status;
            r_out_tag  <= do_remove ? head_tag_w[OUT_TAG_W-1:0] : '0;
            r_out_prio <= do_remove ? head_prio_w[OUT_PRIO_W-1:0] : '0;
            r_held     <= count_w[HELD_W-1:0];
        end
    end

    assign o_status       = r_status;
    assign o_out_tag      = r_out_tag;
    assign o_out_priority = r_out_prio;
    assign o_held_count   = r_held;

endmodule

/* design/priority_ready_queue.sv */
// Sorted ready queue for a task scheduler.
// Input channel (i_valid/o_ready): one request per transfer. i_operation
// selects insert (tag + priority) or remove of the highest-priority entry.
// Entries stay in descending priority; equal priorities leave in arrival order.
// Output channel (o_valid/i_ready): exactly one result per request, carrying
// o_status (done, full, empty), the removed tag/priority (zero otherwise) and
// the entry count after the operation.
// Latency: the result is valid the cycle after the request is taken.
// Throughput: one request per cycle. All cells compare and shift in parallel
// in the same cycle, and a single result register sits on the output.
// A stalled receiver keeps the result register full; o_ready then follows
// i_ready, so a new request is taken exactly when the old result drains.
// Reset (synchronous, active low) empties the queue and the result register.
// Full queue: an insert is refused with status full and nothing changes.
// Empty queue: a remove returns status empty and nothing changes.
module priority_ready_queue #(
    parameter int QUEUE_DEPTH   = prq_pkg::DEF_QUEUE_DEPTH,
    parameter int TAG_BITS      = prq_pkg::DEF_TAG_BITS,
    parameter int PRIORITY_BITS = prq_pkg::DEF_PRIORITY_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [prq_pkg::OP_W-1:0]         i_operation,
    input  logic [prq_pkg::IN_TAG_W-1:0]     i_task_tag,
    input  logic [prq_pkg::IN_PRIO_W-1:0]    i_task_priority,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [prq_pkg::STATUS_W-1:0]     o_status,
    output logic [prq_pkg::OUT_TAG_W-1:0]    o_out_tag,
    output logic [prq_pkg::OUT_PRIO_W-1:0]   o_out_priority,
    output logic [prq_pkg::HELD_W-1:0]       o_held_count
);
    import prq_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    prq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd)
    );

    prq_datapath #(
        .QUEUE_DEPTH   (QUEUE_DEPTH),
        .TAG_BITS      (TAG_BITS),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_operation     (i_operation),
        .i_task_tag      (i_task_tag),
        .i_task_priority (i_task_priority),
        .o_status        (o_status),
        .o_out_tag       (o_out_tag),
        .o_out_priority  (o_out_priority),
        .o_held_count    (o_held_count)
    );

    // a row can never be full and empty at once
    a_full_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(stat.full && stat.empty))
        else $error("queue reports full and empty together");

    // removal from a nonempty queue succeeds and shows up next cycle
    a_remove_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.load && (i_operation == OP_REMOVE) && !stat.empty)
        |=> (o_valid && (o_status == ST_DONE)))
        else $error("remove on nonempty queue not reported done");

    // refused insert leaves the queue full and reports it
    a_insert_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.load && (i_operation == OP_INSERT) && stat.full)
        |=> (stat.full && (o_status == ST_FULL) && (o_out_tag == '0)))
        else $error("insert into full queue mishandled");

    // remove on empty keeps the queue empty with zero payload
    a_remove_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.load && (i_operation == OP_REMOVE) && stat.empty)
        |=> (stat.empty && (o_status == ST_EMPTY) && (o_out_priority == '0)))
        else $error("remove on empty queue mishandled");

endmodule
